>>> sv/pcrrip_pkg.sv
// ============================================================================
// pcrrip_pkg
// Shared types, sizes and helpers for the PC-confidence RRIP replacement block.
// ============================================================================
package pcrrip_pkg;

    // Cache geometry and table size. NUM_SETS and TABLE_ENTRIES are powers of two.
    localparam int NUM_SETS      = 2048;
    localparam int NUM_WAYS      = 16;
    localparam int TABLE_ENTRIES = 16384;

    // Field and storage widths.
    localparam int RRPV_W = 2;
    localparam int CONF_W = 4;
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int ROW_W  = NUM_WAYS * RRPV_W;

    // The confidence table is stored as rows of eight entries.
    localparam int CONF_PER_ROW = 8;
    localparam int CSEL_W       = 3;
    localparam int CONF_ROWS    = TABLE_ENTRIES / CONF_PER_ROW;
    localparam int PC_W         = $clog2(TABLE_ENTRIES);
    localparam int CROW_W       = PC_W - CSEL_W;
    localparam int CROW_BITS    = CONF_PER_ROW * CONF_W;

    // The clearing pass covers the longer of the two memories.
    localparam int CLEAR_ROWS = (NUM_SETS > CONF_ROWS) ? NUM_SETS : CONF_ROWS;
    localparam int CLR_W      = $clog2(CLEAR_ROWS);

    // Policy constants.
    localparam logic [RRPV_W-1:0] RRPV_DISTANT  = 2'd3;
    localparam logic [CONF_W-1:0] CONF_CEIL     = 4'd15;
    localparam logic [CONF_W-1:0] CONF_INIT     = 4'd7;
    localparam logic [CONF_W-1:0] CONF_LOW_TOP  = 4'd4;
    localparam logic [CONF_W-1:0] CONF_MID_TOP  = 4'd9;
    localparam logic [CONF_W-1:0] CONF_MRU      = 4'd14;
    localparam logic [4:0]        BYPASS_WAY    = 5'd16;

    // Operation codes.
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // One request beat.
    typedef struct packed {
        logic        operation;
        logic [10:0] set_index;
        logic [4:0]  way;
        logic [13:0] pc_index;
        logic        is_writeback;
        logic        hit;
    } pcrrip_req_t;

    // One result beat.
    typedef struct packed {
        logic [3:0] victim_way;
        logic       mru_insert;
    } pcrrip_rsp_t;

    // Control of the shared compare unit.
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    // Insertion value for a fill, chosen by confidence class.
    function automatic logic [RRPV_W-1:0] fill_value(input logic [CONF_W-1:0] conf);
        logic [RRPV_W-1:0] v;
        if (conf <= CONF_LOW_TOP)
        begin
            v = 2'd3;
        end
        else if (conf <= CONF_MID_TOP)
        begin
            v = 2'd2;
        end
        else if (conf == CONF_MRU)
        begin
            v = 2'd0;
        end
        else
        begin
            v = 2'd1;
        end
        return v;
    endfunction

endpackage

>>> sv/pcrrip_scan.sv
// ============================================================================
// pcrrip_scan
// Shared compare unit: takes one way per cycle while step is high and keeps the
// largest re-reference value seen and the first way that holds it.
// ============================================================================
module pcrrip_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pcrrip_pkg::scan_ctrl_t      ctrl,
    input  logic [pcrrip_pkg::RRPV_W-1:0] value,
    input  logic [pcrrip_pkg::WAY_W-1:0]  index,
    output logic [pcrrip_pkg::RRPV_W-1:0] top,
    output logic [pcrrip_pkg::WAY_W-1:0]  first
);
    import pcrrip_pkg::*;

    logic [RRPV_W-1:0] top_reg;
    logic [RRPV_W-1:0] top_next;
    logic [WAY_W-1:0]  first_reg;
    logic [WAY_W-1:0]  first_next;

    // A strictly larger value moves the pick, so ties keep the lowest way.
    always_comb
    begin
        top_next   = top_reg;
        first_next = first_reg;
        if (ctrl.clear)
        begin
            top_next   = '0;
            first_next = '0;
        end
        else if (ctrl.step && (value > top_reg))
        begin
            top_next   = value;
            first_next = index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            first_reg <= '0;
        end
        else
        begin
            top_reg   <= top_next;
            first_reg <= first_next;
        end
    end

    assign top   = top_reg;
    assign first = first_reg;

endmodule

>>> sv/pc_confidence_rrip_replacement.sv
// ============================================================================
// pc_confidence_rrip_replacement
// RRIP replacement policy with a PC-indexed confidence table that steers the
// insertion value of fills and is trained by hits and victim picks.
// ============================================================================
//
//  Channel   Ports                  Handshake
//  -------   --------------------   ---------------------------------------
//  request   request, start, busy   beat taken when start is high, busy low
//  result    result, done           beat valid for the single cycle of done
//
//  After reset the block runs a clearing pass over max(NUM_SETS, TABLE_ENTRIES/8)
//  rows (2048) that loads every way value with 3 and every confidence with 7;
//  busy stays high meanwhile. A victim request walks the set through one shared
//  comparator, one way per cycle, through the states READ, SCAN and WRITE; an
//  update request goes through READ and WRITE only. Busy stays high until the
//  request is finished, so a new beat is taken only after it. The receiver
//  cannot stall: done is high for a single cycle per result.
//
module pc_confidence_rrip_replacement (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  pcrrip_pkg::pcrrip_req_t request,
    output logic                    done,
    output pcrrip_pkg::pcrrip_rsp_t result
);
    import pcrrip_pkg::*;

    // Sequencer codes.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CLR_W-1:0]  clr_cnt_reg;
    logic [CLR_W-1:0]  clr_cnt_next;
    logic [WAY_W-1:0]  way_cnt_reg;
    logic [WAY_W-1:0]  way_cnt_next;
    logic              done_reg;
    logic              done_next;
    pcrrip_rsp_t       result_reg;
    pcrrip_rsp_t       result_next;
    pcrrip_req_t       req_reg;

    // Memories with registered read data.
    logic [ROW_W-1:0]     rrpv_mem [NUM_SETS];
    logic [CROW_BITS-1:0] conf_mem [CONF_ROWS];
    logic [ROW_W-1:0]     rrpv_rd_reg;
    logic [CROW_BITS-1:0] conf_rd_reg;

    logic                 mem_rd;
    logic                 rrpv_we;
    logic                 conf_we;
    logic [SET_W-1:0]     rrpv_addr;
    logic [CROW_W-1:0]    conf_addr;
    logic [ROW_W-1:0]     rrpv_wdata;
    logic [CROW_BITS-1:0] conf_wdata;

    // Request decode.
    logic [SET_W-1:0]  set_row;
    logic [PC_W-1:0]   pc_full;
    logic [CSEL_W-1:0] conf_sel;
    logic [CROW_W-1:0] conf_row;
    logic [WAY_W-1:0]  upd_way;
    logic              upd_valid;
    logic [CONF_W-1:0] conf_cur;
    logic [CONF_W-1:0] conf_new;
    logic [RRPV_W-1:0] fill_v;
    logic [RRPV_W-1:0] lift;
    logic [RRPV_W:0]   aged_sum;

    // Shared compare unit.
    scan_ctrl_t        scan_ctrl;
    logic [RRPV_W-1:0] scan_value;
    logic [RRPV_W-1:0] scan_top;
    logic [WAY_W-1:0]  scan_first;

    pcrrip_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .value (scan_value),
        .index (way_cnt_reg),
        .top   (scan_top),
        .first (scan_first)
    );

    // Set and PC wrap to the storage size.
    assign set_row   = SET_W'(32'(req_reg.set_index) & (NUM_SETS - 1));
    assign pc_full   = PC_W'(32'(req_reg.pc_index) & (TABLE_ENTRIES - 1));
    assign conf_sel  = pc_full[CSEL_W-1:0];
    assign conf_row  = pc_full[PC_W-1:CSEL_W];
    assign upd_way   = req_reg.way[WAY_W-1:0];
    assign upd_valid = (req_reg.way != BYPASS_WAY) && (6'(req_reg.way) < 6'(NUM_WAYS));
    assign conf_cur  = conf_rd_reg[conf_sel*CONF_W +: CONF_W];
    assign fill_v    = fill_value(req_reg.is_writeback ? 4'd0 : conf_cur);
    assign lift      = RRPV_DISTANT - scan_top;
    assign scan_value = rrpv_rd_reg[way_cnt_reg*RRPV_W +: RRPV_W];

    // Sequencer and write-back data.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        way_cnt_next = way_cnt_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        scan_ctrl    = '0;
        mem_rd       = 1'b0;
        rrpv_we      = 1'b0;
        conf_we      = 1'b0;
        rrpv_addr    = set_row;
        conf_addr    = conf_row;
        rrpv_wdata   = rrpv_rd_reg;
        conf_wdata   = conf_rd_reg;
        conf_new     = conf_cur;
        aged_sum     = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                rrpv_addr  = SET_W'(clr_cnt_reg);
                conf_addr  = CROW_W'(clr_cnt_reg);
                rrpv_wdata = {NUM_WAYS{RRPV_DISTANT}};
                conf_wdata = {CONF_PER_ROW{CONF_INIT}};
                rrpv_we    = (32'(clr_cnt_reg) < NUM_SETS);
                conf_we    = (32'(clr_cnt_reg) < CONF_ROWS);
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLEAR_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_rd          = 1'b1;
                scan_ctrl.clear = 1'b1;
                way_cnt_next    = '0;
                state_next      = (req_reg.operation == OP_VICTIM) ? ST_SCAN : ST_WRITE;
            end
            ST_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                way_cnt_next   = way_cnt_reg + 1'b1;
                if (way_cnt_reg == WAY_W'(NUM_WAYS - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                done_next              = 1'b1;
                result_next.victim_way = '0;
                result_next.mru_insert = 1'b0;
                state_next             = ST_IDLE;
                if (req_reg.operation == OP_VICTIM)
                begin
                    // Age every way by the lift that brings the largest to 3.
                    for (int w = 0; w < NUM_WAYS; w++)
                    begin
                        aged_sum = {1'b0, rrpv_rd_reg[w*RRPV_W +: RRPV_W]} + {1'b0, lift};
                        rrpv_wdata[w*RRPV_W +: RRPV_W] =
                            (aged_sum > {1'b0, RRPV_DISTANT}) ? RRPV_DISTANT
                                                              : aged_sum[RRPV_W-1:0];
                    end
                    conf_new = (conf_cur != '0) ? conf_cur - 1'b1 : conf_cur;
                    conf_wdata[conf_sel*CONF_W +: CONF_W] = conf_new;
                    rrpv_we  = 1'b1;
                    conf_we  = 1'b1;
                    result_next.victim_way = 4'(scan_first);
                end
                else if (upd_valid)
                begin
                    if (req_reg.hit)
                    begin
                        rrpv_wdata[upd_way*RRPV_W +: RRPV_W] = '0;
                        conf_new = (conf_cur != CONF_CEIL) ? conf_cur + 1'b1 : conf_cur;
                        conf_wdata[conf_sel*CONF_W +: CONF_W] = conf_new;
                        conf_we = 1'b1;
                    end
                    else
                    begin
                        rrpv_wdata[upd_way*RRPV_W +: RRPV_W] = fill_v;
                        result_next.mru_insert = (fill_v == '0);
                    end
                    rrpv_we = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            way_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            way_cnt_reg <= way_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers: the request beat and the result beat.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

    // Way-value memory, one row per set.
    always_ff @(posedge clk)
    begin
        if (rrpv_we)
        begin
            rrpv_mem[rrpv_addr] <= rrpv_wdata;
        end
        if (mem_rd)
        begin
            rrpv_rd_reg <= rrpv_mem[rrpv_addr];
        end
    end

    // Confidence memory, eight entries per row.
    always_ff @(posedge clk)
    begin
        if (conf_we)
        begin
            conf_mem[conf_addr] <= conf_wdata;
        end
        if (mem_rd)
        begin
            conf_rd_reg <= conf_mem[conf_addr];
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
